// ===== hdl/tom_pkg.sv =====
// Shared types, constants and helpers for the track overdub mixer.
`default_nettype none
package tom_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2
  } state_t;

  typedef enum logic [2:0] {
    REG_VOLUME        = 3'd0,
    REG_PAN           = 3'd1,
    REG_RECORD_ON     = 3'd2,
    REG_OVERDUB_ON    = 3'd3,
    REG_PLAYBACK_ON   = 3'd4,
    REG_MUTE_ON       = 3'd5,
    REG_CHANNEL_COUNT = 3'd6,
    REG_START_POS     = 3'd7
  } reg_index_t;

  localparam int          MUL_A_W     = 23;
  localparam int          MUL_B_W     = 24;
  localparam int          PROD_W      = MUL_A_W + MUL_B_W;
  localparam int          RECIP_SHIFT = 30;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;
  // ceil(2^30 / 100), exact floor division for numerators below 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [6:0]  PAN_CENTER  = 7'd50;
  localparam logic [22:0] HALF_100    = 23'd50;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tom_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tom_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/track_overdub_mixer.sv =====
// Track overdub mixer top level: sequencer, shared multiplier and track memory.
//
// Input channel in_*: one Q1.15 sample and its channel index per item.
// Result channel out_*: one mixed Q1.15 sample per input item, in order.
// Config channel cfg_*: register index and data, always ready; write only
// while the block is idle. Writing start_position loads the play position.
// An item passes through the steps MUL1 and DIV1, plus MUL2 and DIV2 when
// pan attenuation applies (stereo, side away from the balance); the next
// item is taken only once the block is back in IDLE. The result is registered
// onto out_valid from the last DIV step. The steps are set by the single
// shared multiplier: each gain and each constant division (done as a reciprocal multiply) takes one pass through it.
// After reset the track memory is cleared one word a cycle, all
// 2 * 2**ceil(log2(min(TRACK_DEPTH, 65536))) words (131072 by default);
// in_ready stays low meanwhile, configuration writes are taken.
// A finished result waits in the output register while out_ready is low;
// the block holds its last step until the register frees up.
`default_nettype none
module track_overdub_mixer #(
  parameter int TRACK_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_sample_in,
  input  wire logic        in_channel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_sample_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int STORE_LEN = (TRACK_DEPTH < 65536) ? TRACK_DEPTH : 65536;
  localparam int SAW       = $clog2(STORE_LEN);
  localparam int AW        = SAW + 1;
  localparam int RAM_DEPTH = 2 ** AW;

  tom_pkg::state_t state_r, state_nxt;

  logic [6:0]  volume_r;
  logic [6:0]  pan_r;
  logic        record_on_r;
  logic        overdub_on_r;
  logic        playback_on_r;
  logic        mute_on_r;
  logic [1:0]  channel_count_r;
  logic [15:0] pos_r, pos_nxt;

  logic          clear_r;
  logic [AW-1:0] clr_cnt_r;

  logic signed [15:0] x_r, x_nxt;
  logic               ch_r, ch_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               inside_r, inside_nxt;
  logic [22:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic signed [17:0] sum_r, sum_nxt;
  logic [15:0]        out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [15:0]          ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [15:0]          ram_rdata;

  logic [6:0]                     vol_sat;
  logic [6:0]                     pan_sat;
  logic [6:0]                     pan_f;
  logic                           pan_apply;
  logic signed [15:0]             stored;
  logic [15:0]                    stored_abs;
  logic [16:0]                    sum_abs;
  logic [tom_pkg::MUL_A_W-1:0]    mul_a;
  logic [tom_pkg::MUL_B_W-1:0]    mul_b;
  logic [tom_pkg::PROD_W-1:0]     prod;
  logic [tom_pkg::QUOT_W-1:0]     quot;
  logic signed [17:0]             quot_s;
  logic signed [17:0]             mix_sum;
  logic signed [17:0]             dub_sum;
  logic                           accept;
  logic                           out_free;
  logic                           advance;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == tom_pkg::ST_IDLE) && !clear_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_r;

  assign vol_sat = (volume_r > tom_pkg::PCT_FULL) ? tom_pkg::PCT_FULL : volume_r;
  assign pan_sat = (pan_r > tom_pkg::PCT_FULL) ? tom_pkg::PCT_FULL : pan_r;
  assign pan_f   = ch_r ? pan_sat : (tom_pkg::PCT_FULL - pan_sat);
  assign pan_apply = (channel_count_r == 2'd2) &&
                     ((!ch_r && (pan_sat > tom_pkg::PAN_CENTER)) ||
                      (ch_r && (pan_sat < tom_pkg::PAN_CENTER)));

  assign stored     = inside_r ? $signed(ram_rdata) : 16'sd0;
  assign stored_abs = stored[15] ? (16'd0 - stored) : stored;
  assign sum_abs    = sum_r[17] ? 17'(-sum_r) : sum_r[16:0];
  assign dub_sum    = 18'(x_r) + (overdub_on_r ? 18'(stored) : 18'sd0);

  // shared multiplier: gains and reciprocal divisions
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      tom_pkg::ST_MUL1: begin
        mul_a = tom_pkg::MUL_A_W'(stored_abs);
        mul_b = tom_pkg::MUL_B_W'(vol_sat);
      end
      tom_pkg::ST_MUL2: begin
        mul_a = tom_pkg::MUL_A_W'(sum_abs);
        mul_b = tom_pkg::MUL_B_W'({pan_f, 1'b0});
      end
      tom_pkg::ST_DIV1, tom_pkg::ST_DIV2: begin
        mul_a = mag_r;
        mul_b = tom_pkg::RECIP_100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = tom_pkg::PROD_W'(mul_a) * tom_pkg::PROD_W'(mul_b);
  assign quot   = prod[tom_pkg::PROD_W-1:tom_pkg::RECIP_SHIFT];
  assign quot_s = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_comb begin
    mix_sum = 18'(x_r) + (playback_on_r ? quot_s : 18'sd0);
    if (mute_on_r) begin
      mix_sum = 18'sd0;
    end
  end

  assign advance = playback_on_r && (channel_count_r != 2'd0) &&
                   ({1'b0, in_channel} == (channel_count_r - 2'd1));

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    ch_nxt        = ch_r;
    addr_nxt      = addr_r;
    inside_nxt    = inside_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sum_nxt       = sum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_nxt       = pos_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = tom_pkg::sat16(dub_sum);
    ram_raddr     = {in_channel, pos_r[SAW-1:0]};

    unique case (state_r)
      tom_pkg::ST_IDLE: begin
        if (accept) begin
          x_nxt      = $signed(in_sample_in);
          ch_nxt     = in_channel;
          addr_nxt   = {in_channel, pos_r[SAW-1:0]};
          inside_nxt = {1'b0, pos_r} < 17'(STORE_LEN);
          if (advance) begin
            pos_nxt = pos_r + 16'd1;
          end
          state_nxt = tom_pkg::ST_MUL1;
        end
      end
      tom_pkg::ST_MUL1: begin
        ram_we    = inside_r && playback_on_r && (record_on_r || overdub_on_r);
        mag_nxt   = prod[22:0] + tom_pkg::HALF_100;
        neg_nxt   = stored[15];
        state_nxt = tom_pkg::ST_DIV1;
      end
      tom_pkg::ST_DIV1: begin
        if (pan_apply) begin
          sum_nxt   = mix_sum;
          state_nxt = tom_pkg::ST_MUL2;
        end else if (out_free) begin
          out_nxt       = tom_pkg::sat16(mix_sum);
          out_valid_nxt = 1'b1;
          state_nxt     = tom_pkg::ST_IDLE;
        end
      end
      tom_pkg::ST_MUL2: begin
        // round(sum * f / 50) as round(2 * sum * f / 100)
        mag_nxt   = prod[22:0] + tom_pkg::HALF_100;
        neg_nxt   = sum_r[17];
        state_nxt = tom_pkg::ST_DIV2;
      end
      tom_pkg::ST_DIV2: begin
        if (out_free) begin
          out_nxt       = tom_pkg::sat16(quot_s);
          out_valid_nxt = 1'b1;
          state_nxt     = tom_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tom_pkg::ST_IDLE;
      end
    endcase

    if (clear_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end

    if (cfg_valid && cfg_ready && (cfg_index == tom_pkg::REG_START_POS)) begin
      pos_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tom_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      clear_r     <= 1'b1;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      if (clear_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == {AW{1'b1}}) begin
          clear_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r        <= tom_pkg::PCT_FULL;
      pan_r           <= tom_pkg::PAN_CENTER;
      record_on_r     <= 1'b0;
      overdub_on_r    <= 1'b0;
      playback_on_r   <= 1'b0;
      mute_on_r       <= 1'b0;
      channel_count_r <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tom_pkg::REG_VOLUME:        volume_r        <= cfg_data[6:0];
        tom_pkg::REG_PAN:           pan_r           <= cfg_data[6:0];
        tom_pkg::REG_RECORD_ON:     record_on_r     <= cfg_data[0];
        tom_pkg::REG_OVERDUB_ON:    overdub_on_r    <= cfg_data[0];
        tom_pkg::REG_PLAYBACK_ON:   playback_on_r   <= cfg_data[0];
        tom_pkg::REG_MUTE_ON:       mute_on_r       <= cfg_data[0];
        tom_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    ch_r     <= ch_nxt;
    addr_r   <= addr_nxt;
    inside_r <= inside_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    sum_r    <= sum_nxt;
    out_r    <= out_nxt;
  end

  tom_ram #(
    .WIDTH(16),
    .DEPTH(RAM_DEPTH)
  ) u_track_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_ready)
    else $error("item accepted during memory clear");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> (ram_we && (ram_wdata == 16'd0) && (ram_waddr == clr_cnt_r)))
    else $error("clear pass writes nonzero or skips");

  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == tom_pkg::ST_MUL1))
    else $error("accepted item did not enter the sequence");

  a_write_only_in_mul1: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !clear_r) |-> (state_r == tom_pkg::ST_MUL1))
    else $error("track write outside read-modify-write step");

  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |->
      ($past(state_r) == tom_pkg::ST_DIV1 || $past(state_r) == tom_pkg::ST_DIV2))
    else $error("result appeared outside a final step");
`endif

endmodule
`default_nettype wire
